>>> rtl/gbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gshare predictor with target buffer.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    // pc bits that feed the pattern table index, pc[8:2]
    localparam logic [63:0] PHT_PC_MASK = 64'h0000_0000_0000_01fe;
    localparam logic [63:0] PC_STEP     = 64'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } gbp_state_t;

    // one entry of the target buffer as read back
    typedef struct packed {
        logic        valid;
        logic        cond;
        logic [63:0] tag;
        logic [63:0] target;
    } btb_rd_t;

    // write request into the target buffer
    typedef struct packed {
        logic        wr_en;
        logic        cond;
        logic [63:0] tag;
        logic [63:0] target;
    } btb_wr_t;

endpackage : gbp_pkg
`default_nettype wire

>>> rtl/gbp_btb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_btb
// Direct-mapped branch target buffer: valid array plus tag/target/kind array,
// registered read, one write port; the valid-bit write is shared with the clearing sweep, which wins.
// ----------------------------------------------------------------------------
module gbp_btb #(
    parameter int INDEX_BITS = 9
) (
    input  wire                      clk,
    input  wire                      rd_en,
    input  wire [INDEX_BITS-1:0]     rd_idx,
    output gbp_pkg::btb_rd_t         rd_data,
    input  wire gbp_pkg::btb_wr_t    wr,
    input  wire [INDEX_BITS-1:0]     wr_idx,
    input  wire                      clr_en,
    input  wire [INDEX_BITS-1:0]     clr_idx
);
    import gbp_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    logic          valid_mem  [DEPTH];
    logic          cond_mem   [DEPTH];
    logic [63:0]   tag_mem    [DEPTH];
    logic [63:0]   target_mem [DEPTH];

    logic          valid_rd_reg;
    logic          cond_rd_reg;
    logic [63:0]   tag_rd_reg;
    logic [63:0]   target_rd_reg;

    // valid array: cleared by the sweep, set by an update
    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            valid_mem[clr_idx] <= 1'b0;
        end
        else if (wr.wr_en)
        begin
            valid_mem[wr_idx] <= 1'b1;
        end
        if (rd_en)
        begin
            valid_rd_reg <= valid_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            cond_mem[wr_idx]   <= wr.cond;
            tag_mem[wr_idx]    <= wr.tag;
            target_mem[wr_idx] <= wr.target;
        end
        if (rd_en)
        begin
            cond_rd_reg   <= cond_mem[rd_idx];
            tag_rd_reg    <= tag_mem[rd_idx];
            target_rd_reg <= target_mem[rd_idx];
        end
    end

    assign rd_data.valid  = valid_rd_reg;
    assign rd_data.cond   = cond_rd_reg;
    assign rd_data.tag    = tag_rd_reg;
    assign rd_data.target = target_rd_reg;

endmodule : gbp_btb
`default_nettype wire

>>> rtl/gshare_btb_branch_predictor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gshare_btb_branch_predictor_top
// Gshare direction predictor with a direct-mapped branch target buffer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pattern table and the buffer's valid bits,
// one entry per cycle for 2^max(HISTORY_BITS, BTB_INDEX_BITS) entries (512 at
// the defaults), with req_stall held high. It then takes one request beat at
// a time: accepting it in ST_IDLE launches the registered pattern table and
// target buffer reads; ST_EXEC forms the prediction into the output register
// or writes back the buffer entry and, if conditional, counter and history.
// A predict beat gives one response beat; an update beat gives none. A
// response waiting on rsp_stall holds off only the following predict.
// ----------------------------------------------------------------------------
module gshare_btb_branch_predictor_top #(
    parameter int HISTORY_BITS   = 8,
    parameter int BTB_INDEX_BITS = 9
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         req_valid,
    output logic        req_stall,
    input  wire         kind,
    input  wire [63:0]  pc,
    input  wire         is_conditional,
    input  wire [63:0]  branch_target,
    input  wire         outcome_taken,
    output logic        rsp_valid,
    input  wire         rsp_stall,
    output logic        predicted_taken,
    output logic [63:0] next_pc
);
    import gbp_pkg::*;

    localparam int PHT_DEPTH = 1 << HISTORY_BITS;
    localparam int CLR_BITS  = (HISTORY_BITS > BTB_INDEX_BITS) ? HISTORY_BITS
                                                               : BTB_INDEX_BITS;

    gbp_state_t                state_reg, state_next;
    logic [CLR_BITS-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [HISTORY_BITS-1:0]   hist_reg, hist_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_taken_reg;
    logic [63:0]               out_pc_reg;

    // captured request beat
    logic                      kind_reg;
    logic [63:0]               pc_reg;
    logic                      cond_reg;
    logic [63:0]               target_reg;
    logic                      taken_reg;
    logic [HISTORY_BITS-1:0]   pht_idx_reg;

    logic [1:0]                pht_mem [PHT_DEPTH];
    logic [1:0]                pht_rd_reg;

    logic                      accept;
    logic                      clr_en;
    logic                      upd_en;
    logic                      rsp_load;
    logic                      rsp_blocked;

    logic [63:0]               pht_pc_bits;
    logic [HISTORY_BITS-1:0]   pht_idx;
    logic [1:0]                cnt_new;
    logic                      pht_we;
    logic [HISTORY_BITS-1:0]   pht_widx;
    logic [1:0]                pht_wdata;

    btb_rd_t                   btb_rd;
    btb_wr_t                   btb_wr;
    logic                      hit;
    logic                      redirect;

    assign accept      = req_valid && !req_stall;
    assign rsp_blocked = out_valid_reg && rsp_stall;

    assign pht_pc_bits = (pc & PHT_PC_MASK) >> 2;
    assign pht_idx     = pht_pc_bits[HISTORY_BITS-1:0] ^ hist_reg;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {CLR_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_UPDATE || !rsp_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        clr_en    = 1'b0;
        upd_en    = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_EXEC:
            begin
                upd_en   = (kind_reg == KIND_UPDATE);
                rsp_load = (kind_reg == KIND_PREDICT) && !rsp_blocked;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign clr_cnt_next   = clr_en ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign hist_next      = (upd_en && cond_reg)
                          ? {hist_reg[HISTORY_BITS-2:0], taken_reg} : hist_reg;
    assign out_valid_next = rsp_load || rsp_blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            pc_reg      <= pc;
            cond_reg    <= is_conditional;
            target_reg  <= branch_target;
            taken_reg   <= outcome_taken;
            pht_idx_reg <= pht_idx;
        end
    end

    // ---------------- pattern table ----------------
    always_comb
    begin
        case (pht_rd_reg)
            2'd0:    cnt_new = taken_reg ? 2'd1 : 2'd0;
            2'd1:    cnt_new = taken_reg ? 2'd2 : 2'd0;
            2'd2:    cnt_new = taken_reg ? 2'd3 : 2'd1;
            2'd3:    cnt_new = taken_reg ? 2'd3 : 2'd2;
            default: cnt_new = 2'd0;
        endcase
    end

    assign pht_we    = clr_en || (upd_en && cond_reg);
    assign pht_widx  = clr_en ? clr_cnt_reg[HISTORY_BITS-1:0] : pht_idx_reg;
    assign pht_wdata = clr_en ? 2'd0 : cnt_new;

    always_ff @(posedge clk)
    begin
        if (pht_we)
        begin
            pht_mem[pht_widx] <= pht_wdata;
        end
        if (accept)
        begin
            pht_rd_reg <= pht_mem[pht_idx];
        end
    end

    // ---------------- target buffer ----------------
    assign btb_wr.wr_en  = upd_en;
    assign btb_wr.cond   = cond_reg;
    assign btb_wr.tag    = pc_reg;
    assign btb_wr.target = target_reg;

    gbp_btb #(
        .INDEX_BITS (BTB_INDEX_BITS)
    ) u_btb (
        .clk     (clk),
        .rd_en   (accept),
        .rd_idx  (pc[BTB_INDEX_BITS+1:2]),
        .rd_data (btb_rd),
        .wr      (btb_wr),
        .wr_idx  (pc_reg[BTB_INDEX_BITS+1:2]),
        .clr_en  (clr_en),
        .clr_idx (clr_cnt_reg[BTB_INDEX_BITS-1:0])
    );

    // ---------------- prediction ----------------
    assign hit      = btb_rd.valid && (btb_rd.tag == pc_reg);
    assign redirect = hit && (!btb_rd.cond || pht_rd_reg[1]);

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_taken_reg <= redirect;
            out_pc_reg    <= redirect ? btb_rd.target : pc_reg + PC_STEP;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign predicted_taken = out_taken_reg;
    assign next_pc         = out_pc_reg;

endmodule : gshare_btb_branch_predictor_top
`default_nettype wire
